FILE: sv/bnms_pkg.sv
`default_nettype none
package bnms_pkg;
    typedef enum logic [2:0] {
        ST_IDLE, ST_BLK, ST_NBR, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic blk_start;
        logic blk_step;
        logic nbr_start;
        logic nbr_step;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic blk_done;
        logic nbr_done;
        logic have;
    } t_sts;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_MASK   = 2'd3;
endpackage
`default_nettype wire

FILE: sv/bnms_ctrl.sv
`default_nettype none
module bnms_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_fire,
    input  wire          i_kind,
    input  wire          i_out_free,
    input  bnms_pkg::t_sts i_sts,
    output bnms_pkg::t_cmd o_cmd,
    output logic         o_busy,
    output logic         o_out_load
);
    bnms_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bnms_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bnms_pkg::ST_IDLE: if (i_in_fire && i_kind) n_state = bnms_pkg::ST_BLK;
            bnms_pkg::ST_BLK: begin
                if (i_sts.blk_done)
                    n_state = i_sts.have ? bnms_pkg::ST_NBR : bnms_pkg::ST_OUT;
            end
            bnms_pkg::ST_NBR: if (i_sts.nbr_done) n_state = bnms_pkg::ST_OUT;
            bnms_pkg::ST_OUT: if (i_out_free) n_state = bnms_pkg::ST_IDLE;
            default: n_state = bnms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = 1'b1;
        o_out_load = 1'b0;
        case (r_state)
            bnms_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                o_cmd.load = i_in_fire && !i_kind;
                o_cmd.blk_start = i_in_fire && i_kind;
            end
            bnms_pkg::ST_BLK: begin
                o_cmd.blk_step = 1'b1;
                o_cmd.nbr_start = i_sts.blk_done;
            end
            bnms_pkg::ST_NBR: o_cmd.nbr_step = 1'b1;
            bnms_pkg::ST_OUT: begin
                o_out_load = i_out_free;
                o_cmd.advance = i_out_free;
            end
            default: o_busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/bnms_datapath.sv
`default_nettype none
module bnms_datapath #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int PIXEL_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  bnms_pkg::t_cmd        i_cmd,
    output bnms_pkg::t_sts        o_sts,
    input  wire [PIXEL_BITS-1:0]  i_pixel,
    input  wire                   i_elig,
    input  wire [8:0]             i_w,
    input  wire [8:0]             i_h,
    input  wire [3:0]             i_s,
    input  wire                   i_mask_en,
    output logic                  o_found,
    output logic [7:0]            o_row,
    output logic [7:0]            o_col,
    output logic                  o_last
);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic                  r_emem [DEPTH];

    logic [16:0] r_load_pos;
    logic [8:0]  r_br, r_bc;        // block origin
    logic [8:0]  r_re, r_ce;        // block end (exclusive)
    logic [8:0]  r_r, r_c;          // scan position
    logic [8:0]  r_r0, r_c0, r_r1, r_c1;
    logic        r_have;
    logic [PIXEL_BITS-1:0] r_cval, r_nmax;
    logic [8:0]  r_cr, r_cc;
    // registered read
    logic [PIXEL_BITS-1:0] r_rd;
    logic        r_rde, r_rdv, r_rdskip;
    logic [8:0]  r_rdr, r_rdc;
    logic        r_scan_end;

    wire [16:0] w_total = 17'(i_w) * 17'(i_h);
    wire [8:0]  w_sp1   = 9'(i_s) + 9'd1;
    // restart at zero when the position lies beyond the frame
    wire [16:0] w_lpos  = (r_load_pos >= w_total) ? 17'd0 : r_load_pos;

    logic [16:0] w_idx;
    assign w_idx = 17'(r_r) * 17'(i_w) + 17'(r_c);

    wire w_scan_last = (r_c + 9'd1 >= (i_cmd.blk_step ? r_ce : r_c1))
                    && (r_r + 9'd1 >= (i_cmd.blk_step ? r_re : r_r1));
    wire w_in_blk = (r_r >= r_br) && (r_r < r_re) && (r_c >= r_bc) && (r_c < r_ce);
    wire w_issue = (i_cmd.blk_step || i_cmd.nbr_step) && !r_scan_end;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[AW'(w_lpos)]  <= i_pixel;
            r_emem[AW'(w_lpos)] <= i_elig;
        end
        r_rd  <= r_mem[AW'(w_idx)];
        r_rde <= r_emem[AW'(w_idx)];
    end

    // candidate neighborhood bounds
    wire [8:0] w_nr0 = (r_cr > 9'(i_s)) ? r_cr - 9'(i_s) : 9'd0;
    wire [8:0] w_nc0 = (r_cc > 9'(i_s)) ? r_cc - 9'(i_s) : 9'd0;
    wire [9:0] w_nr1 = 10'(r_cr) + 10'(w_sp1);
    wire [9:0] w_nc1 = 10'(r_cc) + 10'(w_sp1);

    wire w_el = !i_mask_en || r_rde;
    wire [9:0] w_nbc = 10'(r_bc) + 10'(w_sp1);
    wire [9:0] w_nbr = 10'(r_br) + 10'(w_sp1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos <= '0;
            r_br <= '0;
            r_bc <= '0;
            r_rdv <= 1'b0;
            r_scan_end <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (w_lpos + 17'd1 >= w_total)
                    r_load_pos <= '0;
                else
                    r_load_pos <= w_lpos + 17'd1;
            end
            r_rdv <= w_issue;
            r_rdskip <= i_cmd.nbr_step && w_in_blk;
            r_rdr <= r_r;
            r_rdc <= r_c;
            if (i_cmd.blk_start) begin
                logic [8:0] v_br, v_bc;
                v_br = (r_br >= i_h) ? 9'd0 : r_br;
                v_bc = (r_bc >= i_w) ? 9'd0 : r_bc;
                r_br <= v_br;
                r_bc <= v_bc;
                r_re <= (10'(v_br) + 10'(w_sp1) > 10'(i_h)) ? i_h : v_br + w_sp1;
                r_ce <= (10'(v_bc) + 10'(w_sp1) > 10'(i_w)) ? i_w : v_bc + w_sp1;
                r_r <= v_br;
                r_c <= v_bc;
                r_cr <= v_br;
                r_cc <= v_bc;
                r_have <= 1'b0;
                r_cval <= '0;
                r_scan_end <= 1'b0;
            end else if (i_cmd.nbr_start) begin
                r_r0 <= w_nr0;
                r_c0 <= w_nc0;
                r_r1 <= (w_nr1 > 10'(i_h)) ? i_h : w_nr1[8:0];
                r_c1 <= (w_nc1 > 10'(i_w)) ? i_w : w_nc1[8:0];
                r_r <= w_nr0;
                r_c <= w_nc0;
                r_nmax <= '0;
                r_scan_end <= 1'b0;
            end else if (w_issue) begin
                if (w_scan_last) r_scan_end <= 1'b1;
                else if (r_c + 9'd1 >= (i_cmd.blk_step ? r_ce : r_c1)) begin
                    r_c <= i_cmd.blk_step ? r_bc : r_c0;
                    r_r <= r_r + 9'd1;
                end else r_c <= r_c + 9'd1;
            end
            if (r_rdv && w_el && i_cmd.blk_step) begin
                if (!r_have || r_rd > r_cval) begin
                    r_have <= 1'b1;
                    r_cval <= r_rd;
                    r_cr <= r_rdr;
                    r_cc <= r_rdc;
                end
            end
            if (r_rdv && w_el && i_cmd.nbr_step && !r_rdskip && r_rd > r_nmax)
                r_nmax <= r_rd;
            if (i_cmd.advance) begin
                if (w_nbc >= 10'(i_w)) begin
                    r_bc <= '0;
                    r_br <= (w_nbr >= 10'(i_h)) ? 9'd0 : w_nbr[8:0];
                end else r_bc <= w_nbc[8:0];
            end
        end
    end

    // a scan is done once the final read has been consumed
    wire w_done = r_scan_end && !r_rdv;

    always_comb begin
        o_sts.blk_done = i_cmd.blk_step && w_done;
        o_sts.nbr_done = i_cmd.nbr_step && w_done;
        o_sts.have     = r_have;
        o_found = r_have && (r_cval > r_nmax);
        o_row = r_cr[7:0];
        o_col = r_cc[7:0];
        o_last = (w_nbc >= 10'(i_w)) && (w_nbr >= 10'(i_h));
    end
endmodule
`default_nettype wire

FILE: sv/block_non_max_suppression.sv
// Block non-maximum suppression over a stored frame.
// Input stream (s_axis): tuser = kind (0 load pixel, 1 evaluate block);
// tdata = pixel_value [15:0], pixel_eligible [16], padded to 24 bits.
// A load beat writes one pixel to the frame memory and produces no result. An
// evaluate beat scans the clipped block (at most (s+1)^2 pixels) and then the
// clipped neighborhood of its candidate (at most (2s+1)^2 pixels) from the
// frame memory, one read per cycle through its single read port. Each scan
// ends once its final read has drained, and the result is then loaded into
// the result register for m_axis; a block with no eligible pixel skips the
// neighborhood scan. No input beat is taken until the controller returns to
// idle after the result is loaded.
// Output stream (m_axis): tdata = local_max_found [0], max_row [8:1],
// max_col [16:9], padded to 24 bits; tlast = last_block.
// The result register holds while m_axis_tready is low; the block waits
// in its output state until the register frees.
// Reset clears load position, block origin and controller state; the
// frame memory is not cleared and reads of unwritten pixels are undefined.
// Registers via APB at 4*i: width, height, radius, mask enable.
`default_nettype none
module block_non_max_suppression #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int PIXEL_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [23:0]  s_axis_tdata,   // pixel_value, pixel_eligible
    input  wire         s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // local_max_found, max_row, max_col
    output logic        m_axis_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [8:0] r_w, r_h;
    logic [3:0] r_s;
    logic       r_mask;
    wire [1:0]  w_reg = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 9'd256;
            r_h <= 9'd256;
            r_s <= 4'd3;
            r_mask <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                bnms_pkg::REG_WIDTH:  r_w <= pwdata[8:0];
                bnms_pkg::REG_HEIGHT: r_h <= pwdata[8:0];
                bnms_pkg::REG_RADIUS: r_s <= pwdata[3:0];
                bnms_pkg::REG_MASK:   r_mask <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pready = 1'b1;
        case (w_reg)
            bnms_pkg::REG_WIDTH:  prdata = {23'd0, r_w};
            bnms_pkg::REG_HEIGHT: prdata = {23'd0, r_h};
            bnms_pkg::REG_RADIUS: prdata = {28'd0, r_s};
            bnms_pkg::REG_MASK:   prdata = {31'd0, r_mask};
            default:              prdata = '0;
        endcase
    end

    // clamp dimensions: zero acts as one, cap at the store limits
    localparam logic [8:0] CapW = (MAX_COLS < 256) ? 9'(MAX_COLS) : 9'd256;
    localparam logic [8:0] CapH = (MAX_ROWS < 256) ? 9'(MAX_ROWS) : 9'd256;
    wire [8:0] w_w = (r_w == 9'd0) ? 9'd1 : ((r_w > CapW) ? CapW : r_w);
    wire [8:0] w_h = (r_h == 9'd0) ? 9'd1 : ((r_h > CapH) ? CapH : r_h);

    bnms_pkg::t_cmd w_cmd;
    bnms_pkg::t_sts w_sts;
    logic w_busy, w_out_load;
    logic w_found, w_last;
    logic [7:0] w_row, w_col;

    wire w_out_free = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !w_busy;
    wire w_in_fire = s_axis_tvalid && s_axis_tready;

    bnms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_in_fire),
        .i_kind(s_axis_tuser), .i_out_free(w_out_free), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_busy(w_busy), .o_out_load(w_out_load)
    );

    bnms_datapath #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .PIXEL_BITS(PIXEL_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_pixel(PIXEL_BITS'(s_axis_tdata[15:0])), .i_elig(s_axis_tdata[16]),
        .i_w(w_w), .i_h(w_h), .i_s(r_s), .i_mask_en(r_mask),
        .o_found(w_found), .o_row(w_row), .o_col(w_col), .o_last(w_last)
    );

    // result register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_out_load) m_axis_tvalid <= 1'b1;
        else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        if (w_out_load) begin
            m_axis_tdata <= {7'd0, w_col, w_row, w_found};
            m_axis_tlast <= w_last;
        end
    end
endmodule
`default_nettype wire
